// ===== rtl/core/ntc_pkg.sv =====
// Package for the NTC thermistor table lookup with hysteresis.
// Holds widths, the calibration ROM, the ROM read and divide-by-three helpers.
// No dependencies.
package ntc_pkg;

    localparam int TABLE_DEPTH  = 100;
    localparam int ADC_BITS     = 10;
    localparam int ADC_IN_W     = 10;
    localparam int TEMP_W       = 7;
    localparam int ROM_POINTS   = 100;
    localparam int ROM_W        = 10;
    localparam int IDX_W        = $clog2(ROM_POINTS);
    localparam int SHORTED_TEMP = 100;
    localparam int OPEN_TEMP    = 0;

    localparam int SMP_W = (ADC_BITS < ADC_IN_W) ? ADC_BITS : ADC_IN_W;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (SMP_W > ROM_W + 1) ? SMP_W : ROM_W + 1;

    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_MUL_W = 10;

    localparam logic [ROM_W-1:0] CAL_ROM [ROM_POINTS] = '{
        10'd148, 10'd154, 10'd160, 10'd167, 10'd174, 10'd181, 10'd188, 10'd195, 10'd203,
        10'd211, 10'd219, 10'd227, 10'd235, 10'd243, 10'd252, 10'd261, 10'd270, 10'd279,
        10'd288, 10'd297, 10'd307, 10'd316, 10'd326, 10'd336, 10'd346, 10'd356, 10'd366,
        10'd376, 10'd386, 10'd397, 10'd407, 10'd417, 10'd428, 10'd438, 10'd449, 10'd459,
        10'd470, 10'd480, 10'd490, 10'd501, 10'd511, 10'd521, 10'd532, 10'd542, 10'd552,
        10'd562, 10'd572, 10'd582, 10'd591, 10'd601, 10'd610, 10'd620, 10'd629, 10'd638,
        10'd647, 10'd656, 10'd665, 10'd673, 10'd681, 10'd690, 10'd698, 10'd706, 10'd714,
        10'd721, 10'd729, 10'd736, 10'd743, 10'd750, 10'd757, 10'd764, 10'd771, 10'd777,
        10'd783, 10'd789, 10'd795, 10'd801, 10'd807, 10'd813, 10'd818, 10'd823, 10'd829,
        10'd834, 10'd839, 10'd843, 10'd848, 10'd852, 10'd857, 10'd861, 10'd865, 10'd869,
        10'd873, 10'd877, 10'd881, 10'd884, 10'd888, 10'd891, 10'd895, 10'd898, 10'd901,
        10'd904
    };

    typedef struct packed {
        logic             valid;
        logic             stop;
        logic [CNT_W-1:0] count;
        logic [SMP_W-1:0] sample;
    } cell_data_t;

    function automatic logic [ROM_W-1:0] rom_at(input logic [IDX_W-1:0] idx);
        logic [ROM_W-1:0] val;
        if (int'(idx) >= ROM_POINTS) begin
            val = CAL_ROM[ROM_POINTS-1];
        end
        else begin
            val = CAL_ROM[idx];
        end
        return val;
    endfunction

    // floor(x / 3) for x below 1536
    function automatic logic [ROM_W-1:0] div3(input logic [ROM_W-1:0] x);
        logic [ROM_W+DIV3_MUL_W-1:0] prod;
        prod = (ROM_W + DIV3_MUL_W)'(x) * (ROM_W + DIV3_MUL_W)'(DIV3_MUL);
        return prod[DIV3_SHIFT +: ROM_W];
    endfunction

endpackage

// ===== rtl/core/ntc_cell.sv =====
// One compare cell of the calibration search chain.
// Depends on ntc_pkg for the cell_data_t transaction type.
module ntc_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [ntc_pkg::ROM_W-1:0] entry,
    input  ntc_pkg::cell_data_t      d_in,
    output ntc_pkg::cell_data_t      d_out
);
    import ntc_pkg::*;

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb
    begin
        data_next = d_in;
        if (!d_in.stop && (CMP_W'(d_in.sample) >= CMP_W'(entry))) begin
            data_next.count = d_in.count + CNT_W'(1);
        end
        else begin
            data_next.stop = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            data_reg.valid  <= 1'b0;
            data_reg.stop   <= 1'b0;
            data_reg.count  <= '0;
            data_reg.sample <= '0;
        end
        else if (advance) begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule

// ===== rtl/core/ntc_decide.sv =====
// Open/short checks, hysteresis decision, held temperature and output register.
// Depends on ntc_pkg for ROM reads, divide-by-three and cell_data_t.
module ntc_decide (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  ntc_pkg::cell_data_t       d_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ntc_pkg::TEMP_W-1:0] out_temp
);
    import ntc_pkg::*;

    logic [TEMP_W-1:0] held_reg;
    logic [TEMP_W-1:0] held_next;
    logic [TEMP_W-1:0] out_temp_reg;
    logic              out_valid_reg;
    logic              load;

    logic [IDX_W-1:0]  cand_idx;
    logic [IDX_W-1:0]  held_idx;
    logic [ROM_W-1:0]  lo;
    logic [ROM_W-1:0]  hi;
    logic [ROM_W-1:0]  up;
    logic [ROM_W-1:0]  dn;
    logic [ROM_W:0]    rise_thr;
    logic [ROM_W-1:0]  fall_thr;
    logic [CMP_W-1:0]  smp;

    assign load     = advance && d_in.valid;
    assign cand_idx = IDX_W'(d_in.count);
    assign held_idx = IDX_W'(held_reg);
    assign lo       = rom_at(held_idx);
    assign hi       = rom_at(held_idx + IDX_W'(1));
    assign up       = rom_at(cand_idx);
    assign dn       = rom_at(cand_idx - IDX_W'(1));
    assign rise_thr = {1'b0, lo} + {1'b0, div3(hi - lo)};
    assign fall_thr = up - div3(up - dn);
    assign smp      = CMP_W'(d_in.sample);

    always_comb
    begin
        held_next = held_reg;
        if (d_in.count == '0) begin
            held_next = TEMP_W'(OPEN_TEMP);
        end
        else if (d_in.count >= CNT_W'(TABLE_DEPTH)) begin
            held_next = TEMP_W'(SHORTED_TEMP);
        end
        else if (cand_idx > held_idx) begin
            held_next = (smp >= CMP_W'(rise_thr)) ? TEMP_W'(cand_idx)
                                                 : TEMP_W'(cand_idx - IDX_W'(1));
        end
        else if (cand_idx < held_idx) begin
            held_next = (smp <= CMP_W'(fall_thr)) ? TEMP_W'(cand_idx)
                                                 : TEMP_W'(cand_idx + IDX_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_temp_reg <= held_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_temp  = out_temp_reg;

    a_out_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_temp_reg == held_reg))
        else $error("output temperature differs from held temperature");

    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= TEMP_W'(SHORTED_TEMP))
        else $error("held temperature above maximum");

    a_held_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(held_reg))
        else $error("held temperature changed without a transaction");

    a_no_load_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load)
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/ntc_table_temperature_hysteresis_top.sv =====
// Top level of the NTC thermistor table lookup with hysteresis.
// Depends on ntc_pkg, ntc_cell and ntc_decide.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry raw converter samples; s_tdata[9:0] is
//   the sample, upper bits are zero. m_tvalid/m_tready/m_tdata carry one
//   temperature per sample; m_tdata[6:0] is degrees 0..100, m_tdata[7] is 0.
//   A sample walks a chain of TABLE_DEPTH compare cells, one calibration
//   entry per cell, counting the entries not above it; a final stage applies
//   the open/short checks and the hysteresis against the held temperature.
//   A sample is registered in each cell, then in the final stage's output.
//   Throughput: one sample per cycle unless the receiver stalls, since the
//   chain is pipelined; held temperature is only read at the final stage.
//   Reset clears the held temperature to 0 and empties the chain.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and s_tready drops until the result is taken.
module ntc_table_temperature_hysteresis_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_sample, [15:10] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // [6:0] temperature, [7] zero
);
    import ntc_pkg::*;

    logic              advance;
    cell_data_t        chain [TABLE_DEPTH+1];
    logic [TEMP_W-1:0] temp;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_comb
    begin
        chain[0].valid  = s_tvalid;
        chain[0].stop   = 1'b0;
        chain[0].count  = '0;
        chain[0].sample = s_tdata[SMP_W-1:0];
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        ntc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .entry   (rom_at(IDX_W'(i))),
            .d_in    (chain[i]),
            .d_out   (chain[i+1])
        );
    end

    ntc_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .d_in      (chain[TABLE_DEPTH]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_temp  (temp)
    );

    assign m_tdata = {1'b0, temp};

endmodule
